/* src/kcaf_pkg.sv */
// key click audio filter package: types, constants and saturation helpers
// shared by the controller, the datapath and the divider; depends on nothing
`default_nettype none

package kcaf_pkg;

  localparam int unsigned MAX_BATCH_DEF  = 64;
  localparam int unsigned MAX_WRITES_DEF = 65535;

  localparam int unsigned CNT_W  = 7;
  localparam int unsigned VOL_W  = 15;
  localparam int unsigned SUM_W  = 32;
  localparam int unsigned WC_W   = 16;
  localparam int unsigned ST_W   = 32;
  localparam int unsigned OUT_W  = 21;
  localparam int unsigned DIV_W  = 34;
  localparam int unsigned DSR_W  = 16;

  localparam logic [VOL_W-1:0] CLICK_VOLUME = 15'd32000;
  localparam int unsigned      DECAY_SHIFT  = 14;
  localparam logic signed [46:0] DECAY_NUM  = 47'sh3fe7;

  // divide by three: (2^18 - 1) / 3 for the high part, (2^19 + 1) / 3 reciprocal
  localparam int unsigned  THIRD_LO_W   = 18;
  localparam logic [16:0]  THIRD_HI_MUL = 17'd87381;
  localparam logic [17:0]  THIRD_RECIP  = 18'd174763;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SYNC  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AVG_DIV,
    ST_AVG_WAIT,
    ST_MUL,
    ST_HP_LOAD,
    ST_HP_DECAY,
    ST_LP_SPLIT,
    ST_LP_RECIP,
    ST_LP_UPDATE,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic write_en;
    logic clr_pend;
    logic div_start;
    logic lp_split;
    logic lp_recip;
    logic mul_en;
    logic hp_load;
    logic use_avg;
    logic hp_decay;
    logic lp_update;
    logic emit;
    logic emit_x8;
    logic emit_last;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_nz;
    logic div_done;
    logic out_free;
  } dp_sts_t;

  function automatic logic signed [ST_W-1:0] sat32(input logic signed [35:0] v);
    if (v > 36'sh07fffffff) begin
      return 32'sh7fffffff;
    end else if (v < -36'sh080000000) begin
      return 32'sh80000000;
    end else begin
      return v[ST_W-1:0];
    end
  endfunction

  function automatic logic signed [OUT_W-1:0] sat21(input logic signed [34:0] v);
    if (v > 35'sd1048575) begin
      return 21'sh0fffff;
    end else if (v < -35'sd1048576) begin
      return 21'sh100000;
    end else begin
      return v[OUT_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

/* src/kcaf_div.sv */
// iterative unsigned divider, one quotient bit per cycle
// used for the average of the pending writes; uses kcaf_pkg
`default_nettype none

module kcaf_div import kcaf_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DIV_W-1:0] dividend_i,
  input  wire logic [DSR_W-1:0] divisor_i,
  output logic      [DIV_W-1:0] quotient_o,
  output logic                  done_o
);

  localparam int unsigned CW = $clog2(DIV_W);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DSR_W:0]   rem_q, rem_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DSR_W-1:0] dsr_q, dsr_d;
  logic [DSR_W:0]   shift;
  logic             fits;

  assign shift = {rem_q[DSR_W-1:0], quo_q[DIV_W-1]};
  assign fits  = shift >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DIV_W - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? shift - {1'b0, dsr_q} : shift;
      quo_d = {quo_q[DIV_W-2:0], fits};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

`ifndef SYNTHESIS
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without work");
  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && dsr_q != '0) |-> (rem_q < {1'b0, dsr_q})) else $error("remainder too large");
`endif

endmodule

`default_nettype wire

/* src/kcaf_dp.sv */
// datapath: click level accumulation, high-pass and low-pass filter state,
// decay multiplier, divide by three and output register; uses kcaf_pkg and kcaf_div
`default_nettype none

module kcaf_dp import kcaf_pkg::*; #(
  parameter int unsigned MAX_WRITES = MAX_WRITES_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire dp_cmd_t                 cmd_i,
  output dp_sts_t                      sts_o,
  input  wire logic                    click_level_i,
  input  wire logic                    out_ready_i,
  output logic                         out_valid_o,
  output logic signed [OUT_W-1:0]      out_sample_o,
  output logic                         out_last_o
);

  localparam logic [WC_W-1:0] WritesMax = WC_W'(MAX_WRITES);
  localparam int unsigned     LoW  = THIRD_LO_W;
  localparam int unsigned     HiW  = DIV_W - LoW;
  localparam int unsigned     SumW = LoW + 1;
  localparam int unsigned     HpW  = HiW + 17;
  localparam int unsigned     PrW  = SumW + 18;

  logic                    level_q;
  logic [SUM_W-1:0]        sum_q;
  logic [WC_W-1:0]         wc_q;
  logic [VOL_W-1:0]        prev_q;
  logic signed [ST_W-1:0]  hp_q;
  logic signed [ST_W-1:0]  lp_q;
  logic signed [46:0]      prod_q;
  logic                    neg_q;
  logic                    out_valid_q;
  logic signed [OUT_W-1:0] out_data_q;
  logic                    out_last_q;
  logic [SumW-1:0]         third_sum_q, third_sum_d;
  logic [HpW-1:0]          third_hi_q, third_hi_d;
  logic [DIV_W-1:0]        third_q, third_d;

  logic [DIV_W-1:0]        quo;
  logic                    div_done;
  logic [DIV_W-1:0]        dividend;
  logic [DSR_W-1:0]        divisor;

  logic signed [46:0]      prod_d;
  logic signed [46:0]      prod_adj;
  logic signed [ST_W-1:0]  dec;
  logic [VOL_W-1:0]        cur_vol;
  logic [VOL_W-1:0]        load_vol;
  logic signed [35:0]      hp_in;
  logic signed [DIV_W-1:0] diff2;
  logic [DIV_W-1:0]        mag;
  logic [PrW-1:0]          third_prod;
  logic signed [35:0]      q_signed;
  logic signed [35:0]      lp_sum;
  logic signed [34:0]      x8;
  logic signed [34:0]      x7;

  assign prod_d   = 47'(hp_q) * DECAY_NUM;
  assign prod_adj = prod_q + (prod_q[46] ? 47'sd16383 : 47'sd0);
  assign dec      = ST_W'(prod_adj >>> DECAY_SHIFT);

  assign cur_vol  = level_q ? CLICK_VOLUME : '0;
  assign load_vol = cmd_i.use_avg ? quo[VOL_W-1:0] : cur_vol;
  assign hp_in    = $signed({21'b0, load_vol}) - $signed({21'b0, prev_q}) + 36'(dec);

  assign diff2    = (DIV_W'(hp_q) - DIV_W'(lp_q)) <<< 1;
  assign mag      = diff2[DIV_W-1] ? DIV_W'(-diff2) : diff2;

  // mag / 3 = hi * (2^18 - 1) / 3 + (hi + lo) / 3
  assign third_sum_d = SumW'(mag[DIV_W-1:LoW]) + SumW'(mag[LoW-1:0]);
  assign third_hi_d  = HpW'(mag[DIV_W-1:LoW]) * HpW'(THIRD_HI_MUL);
  assign third_prod  = PrW'(third_sum_q) * PrW'(THIRD_RECIP);
  assign third_d     = DIV_W'(third_hi_q) + DIV_W'(third_prod[PrW-1:SumW]);

  assign q_signed = neg_q ? -$signed({2'b0, third_q}) : $signed({2'b0, third_q});
  assign lp_sum   = 36'(lp_q) + q_signed;

  assign x8 = 35'(lp_q) <<< 3;
  assign x7 = x8 - 35'(lp_q);

  assign dividend = {2'b0, sum_q};
  assign divisor  = wc_q;

  kcaf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .quotient_o (quo),
    .done_o     (div_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= 1'b0;
      sum_q       <= '0;
      wc_q        <= '0;
      prev_q      <= '0;
      hp_q        <= '0;
      lp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.write_en) begin
        level_q <= click_level_i;
        if (wc_q < WritesMax) begin
          wc_q  <= wc_q + 1'b1;
          sum_q <= sum_q + (click_level_i ? SUM_W'(CLICK_VOLUME) : '0);
        end
      end else if (cmd_i.clr_pend) begin
        wc_q  <= '0;
        sum_q <= '0;
      end
      if (cmd_i.hp_load) begin
        hp_q   <= sat32(hp_in);
        prev_q <= load_vol;
      end else if (cmd_i.hp_decay) begin
        hp_q <= dec;
      end
      if (cmd_i.lp_update) begin
        lp_q <= sat32(lp_sum);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.lp_split) begin
      neg_q       <= diff2[DIV_W-1];
      third_sum_q <= third_sum_d;
      third_hi_q  <= third_hi_d;
    end
    if (cmd_i.lp_recip) begin
      third_q <= third_d;
    end
    if (cmd_i.emit) begin
      out_data_q <= sat21(cmd_i.emit_x8 ? x8 : x7);
      out_last_q <= cmd_i.emit_last;
    end
  end

  assign sts_o.cnt_nz   = wc_q != '0;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_data_q;
  assign out_last_o   = out_last_q;

`ifndef SYNTHESIS
  a_wc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wc_q <= WritesMax) else $error("write count beyond limit");
  a_lp_after_recip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.lp_update |-> $past(cmd_i.lp_recip)) else $error("low-pass update without quotient");
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> out_valid_q) else $error("emitted sample not presented");
`endif

endmodule

`default_nettype wire

/* src/kcaf_ctrl.sv */
// controller state machine: sequences writes, averaging, filter steps and
// the sample batch; uses kcaf_pkg, drives the datapath by command struct
`default_nettype none

module kcaf_ctrl import kcaf_pkg::*; #(
  parameter int unsigned MAX_BATCH = MAX_BATCH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             in_op_i,
  input  wire logic [CNT_W-1:0] in_count_i,
  output logic                  in_ready_o,
  input  wire dp_sts_t          sts_i,
  output dp_cmd_t               cmd_o
);

  localparam logic [CNT_W-1:0] BatchMax = CNT_W'(MAX_BATCH);

  ctrl_state_e      state_q, state_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic [CNT_W-1:0] i_q, i_d;
  logic             first_q, first_d;
  logic             load_q, load_d;
  logic [CNT_W-1:0] i_next;
  logic             sync_req;

  assign i_next   = i_q + 1'b1;
  assign sync_req = in_valid_i && (in_op_i == OP_SYNC);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (sync_req) begin
          state_d = sts_i.cnt_nz ? ST_AVG_DIV : ST_MUL;
        end
      end
      ST_AVG_DIV: state_d = ST_AVG_WAIT;
      ST_AVG_WAIT: begin
        if (sts_i.div_done) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: state_d = load_q ? ST_HP_LOAD : ST_HP_DECAY;
      ST_HP_LOAD: begin
        if (first_q || (i_q < n_q)) begin
          state_d = ST_MUL;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_HP_DECAY: state_d = ST_LP_SPLIT;
      ST_LP_SPLIT: state_d = ST_LP_RECIP;
      ST_LP_RECIP: state_d = ST_LP_UPDATE;
      ST_LP_UPDATE: state_d = (first_q && n_q == '0) ? ST_MUL : ST_EMIT;
      ST_EMIT: begin
        if (sts_i.out_free) begin
          state_d = (first_q || (i_next < n_q)) ? ST_MUL : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // batch counters and phase flags
  always_comb begin
    n_d     = n_q;
    i_d     = i_q;
    first_d = first_q;
    load_d  = load_q;
    case (state_q)
      ST_IDLE: begin
        if (sync_req) begin
          n_d     = (in_count_i > BatchMax) ? BatchMax : in_count_i;
          i_d     = '0;
          first_d = sts_i.cnt_nz;
          load_d  = 1'b1;
        end
      end
      ST_HP_LOAD: load_d = 1'b0;
      ST_LP_UPDATE: begin
        if (first_q && n_q == '0) begin
          first_d = 1'b0;
          load_d  = 1'b1;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          i_d = i_next;
          if (first_q) begin
            first_d = 1'b0;
            load_d  = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.write_en = in_valid_i && (in_op_i == OP_WRITE);
      end
      ST_AVG_DIV: cmd_o.div_start = 1'b1;
      ST_AVG_WAIT: cmd_o.clr_pend = sts_i.div_done;
      ST_MUL: cmd_o.mul_en = 1'b1;
      ST_HP_LOAD: begin
        cmd_o.hp_load = 1'b1;
        cmd_o.use_avg = first_q;
      end
      ST_HP_DECAY: cmd_o.hp_decay = 1'b1;
      ST_LP_SPLIT: cmd_o.lp_split = 1'b1;
      ST_LP_RECIP: cmd_o.lp_recip = 1'b1;
      ST_LP_UPDATE: cmd_o.lp_update = 1'b1;
      ST_EMIT: begin
        cmd_o.emit      = sts_i.out_free;
        cmd_o.emit_x8   = first_q;
        cmd_o.emit_last = i_next == n_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      n_q     <= '0;
      i_q     <= '0;
      first_q <= 1'b0;
      load_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      i_q     <= i_d;
      first_q <= first_d;
      load_q  <= load_d;
    end
  end

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free) else $error("sample emitted into full output");
  a_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (i_q <= n_q)) else $error("sample index beyond batch");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && cmd_o.emit_last && !first_q) |=> (state_q == ST_IDLE))
    else $error("batch continues after last sample");
  a_batch_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= BatchMax) else $error("batch size beyond limit");
`endif

endmodule

`default_nettype wire

/* src/key_click_audio_filter.sv */
// key click audio filter top level: stream ports, controller and datapath
// depends on kcaf_pkg, kcaf_ctrl, kcaf_dp (and kcaf_div below it)
//
//  channel  dir  handshake             payload
//  s_axis   in   tvalid/tready         tuser: operation; tdata: click_level, sample_count
//  m_axis   out  tvalid/tready/tlast   tdata: audio_sample; tlast: last_sample
//
// a write request is taken while idle; the next request can follow in the next cycle
// a sync request for n samples runs a decay multiply and level edge load, then per
// sample a decay multiply, high-pass, three low-pass steps and an output load
// pending writes first run the average divide and load the average into the high-pass
// reset clears all filter state, the write sum and count, and the output valid flag
// a stalled output holds the batch only when the next sample is ready to load
`default_nettype none

module key_click_audio_filter import kcaf_pkg::*; #(
  parameter int unsigned MAX_BATCH  = MAX_BATCH_DEF,
  parameter int unsigned MAX_WRITES = MAX_WRITES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [0] click_level, [7:1] sample_count
  input  wire logic        s_axis_tuser,   // [0] operation
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [20:0] audio_sample, [23:21] zero
  output logic             m_axis_tlast    // last_sample
);

  dp_cmd_t                 cmd;
  dp_sts_t                 sts;
  logic signed [OUT_W-1:0] sample;

  kcaf_ctrl #(
    .MAX_BATCH (MAX_BATCH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_count_i (s_axis_tdata[7:1]),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kcaf_dp #(
    .MAX_WRITES (MAX_WRITES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .click_level_i (s_axis_tdata[0]),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_sample_o  (sample),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, sample};

endmodule

`default_nettype wire
